// ----- sv/slot_table_first_free_search_top_assert.svh -----
`ifndef SLOT_TABLE_FIRST_FREE_SEARCH_TOP_ASSERT_SVH
`define SLOT_TABLE_FIRST_FREE_SEARCH_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/stfs_pkg.sv -----
package stfs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 8;

  // Depth of the request queue between front and back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_FIND       = 2'd1,
    OP_REMOVE_VAL = 2'd2,
    OP_REMOVE_IDX = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_SCAN,
    BK_IDX
  } bk_state_e;

  typedef struct packed {
    opcode_e                  op;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        slot_index;
  } cmd_t;

endpackage

// ----- sv/stfs_req_if.sv -----
interface stfs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;
  logic [7:0]         slot_index;

  modport source (output valid, output opcode, output value, output slot_index, input ready);
  modport sink (input valid, input opcode, input value, input slot_index, output ready);
endinterface

// ----- sv/stfs_rsp_if.sv -----
interface stfs_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         slot;
  logic signed [31:0] data;

  modport source (output valid, output status, output slot, output data, input ready);
  modport sink (input valid, input status, input slot, input data, output ready);
endinterface

// ----- sv/stfs_front.sv -----
module stfs_front (
  stfs_req_if.sink      req_i,
  output stfs_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import stfs_pkg::*;

  assign cmd_o.op         = opcode_e'(req_i.opcode);
  assign cmd_o.value      = req_i.value;
  assign cmd_o.slot_index = req_i.slot_index;
  assign cmd_valid_o      = req_i.valid;
  assign req_i.ready      = cmd_ready_i;

endmodule

// ----- sv/stfs_queue.sv -----
module stfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  stfs_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output stfs_pkg::cmd_t pop_cmd_o
);
  import stfs_pkg::*;

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = count_q != QCntW'(QDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- sv/stfs_back.sv -----
module stfs_back #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  stfs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  stfs_rsp_if.source     rsp_o
);
  import stfs_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned HW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (HW > IndexW) ? HW : IndexW;
  localparam logic [HW-1:0] CapW = HW'(CAPACITY);

  bk_state_e state_q, state_d;

  cmd_t                     cur_q;
  logic [HW-1:0]            hw_q;
  logic [CAPACITY-1:0]      used_q;
  logic signed [ValueW-1:0] mem [CAPACITY];
  logic signed [ValueW-1:0] rdata_q;

  logic [HW-1:0] iss_q;
  logic [AW-1:0] cmp_idx_q;
  logic          cmp_used_q;
  logic          cmp_vld_q;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [IndexW-1:0]        out_slot_q;
  logic signed [ValueW-1:0] out_data_q;

  logic                     in_range;
  logic [AW-1:0]            idx_addr;
  logic                     iss_more;
  logic                     hit;
  logic                     scan_end;
  logic                     is_full;

  logic                     scan_clear;
  logic                     scan_step;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic                     set_used;
  logic                     clr_used;
  logic [AW-1:0]            used_addr;
  logic                     hw_inc;
  logic                     res_load;
  status_e                  res_status;
  logic [IndexW-1:0]        res_slot;
  logic signed [ValueW-1:0] res_data;

  assign in_range = CW'(cur_q.slot_index) < CW'(hw_q);
  assign idx_addr = AW'(cur_q.slot_index);
  assign iss_more = iss_q < hw_q;
  assign is_full  = hw_q == CapW;
  assign scan_end = !cmp_vld_q && !iss_more;

  always_comb begin
    if (cur_q.op == OP_INSERT) begin
      hit = cmp_vld_q && !cmp_used_q;
    end else begin
      hit = cmp_vld_q && cmp_used_q && (rdata_q == cur_q.value);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          state_d = BK_START;
        end
      end
      BK_START: begin
        if (cur_q.op == OP_REMOVE_IDX) begin
          state_d = in_range ? BK_IDX : BK_IDLE;
        end else begin
          state_d = BK_SCAN;
        end
      end
      BK_IDX: begin
        state_d = BK_IDLE;
      end
      BK_SCAN: begin
        if (hit || scan_end) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    scan_clear = 1'b0;
    scan_step  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = iss_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = cmp_idx_q;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    used_addr  = cmp_idx_q;
    hw_inc     = 1'b0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_data   = '0;
    case (state_q)
      BK_IDLE: begin
        scan_clear = 1'b1;
        cmd_pop_o  = cmd_valid_i && !out_valid_q;
      end
      BK_START: begin
        if (cur_q.op == OP_REMOVE_IDX) begin
          if (in_range) begin
            rd_en   = 1'b1;
            rd_addr = idx_addr;
          end else begin
            res_load   = 1'b1;
            res_status = ST_RANGE;
          end
        end
      end
      BK_IDX: begin
        res_load  = 1'b1;
        res_slot  = cur_q.slot_index;
        res_data  = rdata_q;
        clr_used  = 1'b1;
        used_addr = idx_addr;
      end
      BK_SCAN: begin
        scan_step = 1'b1;
        rd_en     = iss_more;
        if (hit) begin
          res_load = 1'b1;
          res_slot = IndexW'(cmp_idx_q);
          case (cur_q.op)
            OP_INSERT: begin
              wr_en    = 1'b1;
              set_used = 1'b1;
            end
            OP_REMOVE_VAL: begin
              clr_used = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (scan_end) begin
          res_load = 1'b1;
          if (cur_q.op != OP_INSERT) begin
            res_status = ST_NOT_FOUND;
          end else if (is_full) begin
            res_status = ST_FULL;
          end else begin
            res_slot  = IndexW'(hw_q);
            wr_en     = 1'b1;
            wr_addr   = AW'(hw_q);
            set_used  = 1'b1;
            used_addr = AW'(hw_q);
            hw_inc    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      hw_q        <= '0;
      used_q      <= '0;
      iss_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (hw_inc) begin
        hw_q <= hw_q + 1'b1;
      end
      if (set_used) begin
        used_q[used_addr] <= 1'b1;
      end else if (clr_used) begin
        used_q[used_addr] <= 1'b0;
      end
      if (scan_clear) begin
        iss_q     <= '0;
        cmp_vld_q <= 1'b0;
      end else if (scan_step) begin
        cmp_vld_q <= iss_more;
        if (iss_more) begin
          iss_q <= iss_q + 1'b1;
        end
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
    end
    if (scan_step) begin
      cmp_idx_q  <= iss_q[AW-1:0];
      cmp_used_q <= used_q[iss_q[AW-1:0]];
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_data_q   <= res_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cur_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.slot   = out_slot_q;
  assign rsp_o.data   = out_data_q;

endmodule

// ----- sv/slot_table_first_free_search_top.sv -----
// Slot table with first-free allocation and value search. Requests enter through a
// two-entry queue, so up to two further requests are taken while one is being worked
// on or while its answer waits to be collected. The values sit in a single-port-read
// memory of CAPACITY entries and every search walks it one slot per clock up to the
// high-water length: an insert, find or remove by value stops at its first hit or at
// that length, a remove by index reads its slot and answers, and one with an index out
// of range is answered without a read. No clearing pass is needed after reset, since
// only slots below the high-water length are ever read and each has been written.
module slot_table_first_free_search_top #(
  parameter int unsigned CAPACITY = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  stfs_req_if.sink   req_i,
  stfs_rsp_if.source rsp_o
);
  import stfs_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t queue_cmd;
  logic queue_valid;
  logic queue_pop;

  stfs_front u_front (
    .req_i       (req_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  stfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop),
    .pop_cmd_o    (queue_cmd)
  );

  stfs_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- sv/stfs_checker.sv -----
`include "slot_table_first_free_search_top_assert.svh"

module stfs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [1:0]         rsp_status_i,
  input logic [7:0]         rsp_slot_i,
  input logic signed [31:0] rsp_data_i
);
  import stfs_pkg::*;

  // At most the queue plus one request in the back end or its output register.
  localparam int unsigned InFlightMax = QDepth + 1;

  logic [2:0] inflight_q, inflight_d;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (req_acc && !rsp_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (rsp_acc && !req_acc) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `ASSERT_IMPLIES(a_rsp_needs_req, rsp_valid_i, inflight_q != 3'd0, "answer without a request")
  `ASSERT_IMPLIES(a_inflight_bound, 1'b1, inflight_q <= 3'(InFlightMax), "too many requests held")
  `ASSERT_IMPLIES(a_err_no_payload, rsp_valid_i && (rsp_status_i != ST_OK), (rsp_slot_i == 8'd0) && (rsp_data_i == 32'sd0), "error answer carries a slot or data")
  `ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_slot_i) && $stable(rsp_data_i), "stalled answer changed")

endmodule

bind slot_table_first_free_search_top stfs_checker u_stfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_data_i   (rsp_o.data)
);

// ----- dv/slot_table_first_free_search_top_tb.sv -----
module slot_table_first_free_search_top_tb;
  import stfs_pkg::*;

  localparam int unsigned Capacity  = 256;
  localparam int unsigned CalmTail  = 150;
  localparam longint      RunLimit  = 64'd18_000_000;

  typedef struct packed {
    status_e                  status;
    logic [IndexW-1:0]        slot;
    logic signed [ValueW-1:0] data;
  } answer_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     req_valid = 1'b0;
  opcode_e                  req_op    = OP_INSERT;
  logic signed [ValueW-1:0] req_value = '0;
  logic [IndexW-1:0]        req_index = '0;
  logic                     rsp_ready = 1'b0;

  stfs_req_if req_if ();
  stfs_rsp_if rsp_if ();

  assign req_if.valid      = req_valid;
  assign req_if.opcode     = req_op;
  assign req_if.value      = req_value;
  assign req_if.slot_index = req_index;
  assign rsp_if.ready      = rsp_ready;

  slot_table_first_free_search_top #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  cmd_t    pending_q[$];
  answer_t answer_q[$];
  cmd_t    next_cmd;

  logic signed [ValueW-1:0] table_value[Capacity];
  bit                       table_used[Capacity];
  int unsigned              table_length = 0;
  logic signed [ValueW-1:0] value_pool[16];

  int unsigned req_gap = 0;
  int unsigned rsp_gap = 0;
  int unsigned n_total = 0;
  int unsigned n_accepted = 0;
  int unsigned n_ok = 0;
  int unsigned n_absent = 0;
  int unsigned n_full = 0;
  int unsigned n_range = 0;
  int unsigned n_errors = 0;

  function automatic bit calm_tail();
    return pending_q.size() < CalmTail;
  endfunction

  function automatic void add_req(opcode_e op, logic signed [ValueW-1:0] v,
                                  logic [IndexW-1:0] idx);
    cmd_t c;
    c.op = op;
    c.value = v;
    c.slot_index = idx;
    pending_q.push_back(c);
    n_total++;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) begin
      return value_pool[$urandom_range(0, 15)];
    end
    return $urandom;
  endfunction

  function automatic opcode_e pick_op(int unsigned w_ins, int unsigned w_find,
                                      int unsigned w_rmv);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return OP_INSERT;
    if (r < w_ins + w_find) return OP_FIND;
    if (r < w_ins + w_find + w_rmv) return OP_REMOVE_VAL;
    return OP_REMOVE_IDX;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  // Works out the answer to one accepted request and updates the shadow table.
  task automatic predict_request(cmd_t c);
    answer_t     a;
    int unsigned i;
    bit          hit;
    a.status = ST_OK;
    a.slot = '0;
    a.data = '0;
    hit = 1'b0;
    case (c.op)
      OP_INSERT: begin
        for (i = 0; i < table_length; i++) begin
          if (!table_used[i]) begin
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          table_value[i] = c.value;
          table_used[i] = 1'b1;
          a.slot = i[IndexW-1:0];
        end else if (table_length >= Capacity) begin
          a.status = ST_FULL;
        end else begin
          table_value[table_length] = c.value;
          table_used[table_length] = 1'b1;
          a.slot = table_length[IndexW-1:0];
          table_length++;
        end
      end
      OP_FIND, OP_REMOVE_VAL: begin
        for (i = 0; i < table_length; i++) begin
          if (table_used[i] && table_value[i] == c.value) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) begin
          a.status = ST_NOT_FOUND;
        end else begin
          if (c.op == OP_REMOVE_VAL) table_used[i] = 1'b0;
          a.slot = i[IndexW-1:0];
        end
      end
      default: begin
        if (c.slot_index >= table_length) begin
          a.status = ST_RANGE;
        end else begin
          table_used[c.slot_index] = 1'b0;
          a.slot = c.slot_index;
          a.data = table_value[c.slot_index];
        end
      end
    endcase
    case (a.status)
      ST_OK:        n_ok++;
      ST_NOT_FOUND: n_absent++;
      ST_FULL:      n_full++;
      default:      n_range++;
    endcase
    answer_q.push_back(a);
    n_accepted++;
  endtask

  task automatic check_response();
    answer_t want;
    if (answer_q.size() == 0) begin
      report_mismatch("response with no request outstanding", rsp_if.status, 0);
      return;
    end
    want = answer_q.pop_front();
    if (rsp_if.status !== want.status) begin
      report_mismatch("status", rsp_if.status, want.status);
    end
    if (rsp_if.slot !== want.slot) begin
      report_mismatch("slot", rsp_if.slot, want.slot);
    end
    if (rsp_if.data !== want.data) begin
      report_mismatch("data", rsp_if.data, want.data);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_gap <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        next_cmd.op = req_op;
        next_cmd.value = req_value;
        next_cmd.slot_index = req_index;
        predict_request(next_cmd);
      end
      if (!req_valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_valid <= 1'b0;
          req_gap <= req_gap - 1;
        end else if (pending_q.size() != 0) begin
          next_cmd = pending_q.pop_front();
          req_valid <= 1'b1;
          req_op <= next_cmd.op;
          req_value <= next_cmd.value;
          req_index <= next_cmd.slot_index;
          if (!calm_tail() && $urandom_range(0, 5) == 0) begin
            req_gap <= $urandom_range(1, 15);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      rsp_gap <= 0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin
        check_response();
      end
      if (rsp_gap != 0) begin
        rsp_ready <= 1'b0;
        rsp_gap <= rsp_gap - 1;
      end else begin
        rsp_ready <= 1'b1;
        if (!calm_tail() && $urandom_range(0, 7) == 0) begin
          rsp_gap <= $urandom_range(1, 15);
        end
      end
    end
  end

  initial begin
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (int k = 4; k < 16; k++) begin
      value_pool[k] = $urandom;
    end

    // Each special case on a small table first.
    add_req(OP_REMOVE_IDX, '0, 8'd0);
    add_req(OP_FIND, 32'sd5, 8'd0);
    add_req(OP_REMOVE_VAL, 32'sd5, 8'd0);
    add_req(OP_INSERT, 32'sh8000_0000, 8'd0);
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 8'hFF);
    add_req(OP_INSERT, '0, 8'd0);
    add_req(OP_INSERT, -1, 8'd0);
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 8'd0);
    add_req(OP_FIND, 32'sh7FFF_FFFF, 8'd0);
    add_req(OP_FIND, -1, 8'hFF);
    add_req(OP_REMOVE_VAL, 32'sh7FFF_FFFF, 8'd0);
    add_req(OP_FIND, 32'sh7FFF_FFFF, 8'd0);
    add_req(OP_INSERT, 32'sh5A5A_5A5A, 8'd0);
    add_req(OP_REMOVE_IDX, '0, 8'd3);
    add_req(OP_REMOVE_IDX, '0, 8'd3);
    add_req(OP_REMOVE_IDX, '0, 8'd5);
    add_req(OP_REMOVE_IDX, -1, 8'hFF);
    add_req(OP_FIND, -1, 8'd0);
    add_req(OP_REMOVE_VAL, '0, 8'd0);
    add_req(OP_INSERT, 32'sh1234_5678, 8'd0);
    add_req(OP_FIND, 32'sh8000_0000, 8'd0);

    for (int k = 0; k < 400; k++) begin
      add_req(pick_op(35, 25, 20), pick_value(),
              ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 31)));
    end

    // Enough inserts to fill the table whatever the mix above left behind.
    for (int k = 0; k < 300; k++) begin
      add_req(OP_INSERT, pick_value(), 8'($urandom));
    end
    add_req(OP_REMOVE_IDX, '0, 8'hFF);
    add_req(OP_INSERT, 32'sh7FFF_FFFF, 8'd0);
    add_req(OP_INSERT, 32'sh8000_0000, 8'd0);
    add_req(OP_FIND, 32'sh7FFF_FFFF, 8'd0);

    for (int k = 0; k < 500; k++) begin
      add_req(pick_op(30, 25, 20), pick_value(), 8'($urandom_range(0, 255)));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_total || answer_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (Capacity + 20) @(posedge clk_i);

    $display("Ran %0d requests on a %0d-slot table: %0d ok, %0d value absent,",
             n_total, Capacity, n_ok, n_absent);
    $display("%0d table full, %0d index out of range; high-water length reached %0d.",
             n_full, n_range, table_length);
    if (n_errors == 0) begin
      $display("slot_table_first_free_search_top test passed");
    end else begin
      $display("slot_table_first_free_search_top test failed");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("Timed out with %0d of %0d requests accepted.", n_accepted, n_total);
    $display("slot_table_first_free_search_top test failed");
    $finish;
  end

endmodule
